### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define CHK_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/drop_pkg.sv
`default_nettype none
package drop_pkg;

    typedef enum logic [3:0] {
        OP_MAX  = 4'd0,
        OP_MIN  = 4'd1,
        OP_SUM  = 4'd2,
        OP_PROD = 4'd3,
        OP_LAND = 4'd4,
        OP_BAND = 4'd5,
        OP_LOR  = 4'd6,
        OP_BOR  = 4'd7,
        OP_LXOR = 4'd8
    } op_t;

    localparam logic [63:0] ONE_BITS = 64'h3FF0000000000000;
    localparam logic [63:0] DFLT_NAN = 64'h7FF8000000000000;
    localparam logic [63:0] QNAN_BIT = 64'h0008000000000000;

    function automatic logic is_nan(input logic [63:0] u);
        is_nan = (u[62:52] == 11'h7FF) && (u[51:0] != 52'd0);
    endfunction

    function automatic logic truth(input logic [63:0] u);
        truth = (u[62:0] != 63'd0);
    endfunction

    // Truncate toward zero to a saturated signed 64-bit integer
    function automatic logic [63:0] trunc_sat(input logic [63:0] u);
        logic [10:0]  ex;
        logic [63:0]  mag;
        logic [10:0]  sh;
        ex  = u[62:52];
        mag = {11'd0, 1'b1, u[51:0]};
        sh  = 11'd0;
        if (is_nan(u) || ex < 11'd1023) begin
            trunc_sat = 64'd0;
        end else if (ex >= 11'd1086) begin
            trunc_sat = u[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        end else begin
            if (ex >= 11'd1075) begin
                sh  = ex - 11'd1075;
                mag = mag << sh[5:0];
            end else begin
                sh  = 11'd1075 - ex;
                mag = mag >> sh[5:0];
            end
            trunc_sat = u[63] ? (~mag + 64'd1) : mag;
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/drop_fadd.sv
`default_nettype none
// Double add, round to nearest even, three register stages:
// align, add and normalize, round.
module drop_fadd (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic [63:0]      sum
);
    // Stage 1 registers: aligned operands
    logic        s1_sign_reg, s1_sub_reg, s1_spec_reg, s1_bsign_reg;
    logic [63:0] s1_spec_val_reg;
    logic [10:0] s1_exp_reg;
    logic [55:0] s1_big_reg, s1_small_reg;

    logic        ax, bx;
    logic [10:0] ea, eb, eh, el;
    logic [52:0] ma, mb;
    logic        swap;
    logic [52:0] mh, ml;
    logic [10:0] d;
    logic [55:0] lo_ext, lo_sh;
    logic        sticky;
    logic        spec;
    logic [63:0] spec_val;
    logic        sh_s, sl_s;

    always_comb
    begin
        ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        ma = {(a[62:52] != 11'd0), a[51:0]};
        mb = {(b[62:52] != 11'd0), b[51:0]};
        swap = {eb, mb} > {ea, ma};
        eh = swap ? eb : ea;
        el = swap ? ea : eb;
        mh = swap ? mb : ma;
        ml = swap ? ma : mb;
        sh_s = swap ? b[63] : a[63];
        sl_s = swap ? a[63] : b[63];
        d = eh - el;
        lo_ext = {ml, 3'b000};
        if (d > 11'd55) begin
            lo_sh  = 56'd0;
            sticky = (ml != 53'd0);
        end else begin
            lo_sh  = lo_ext >> d[5:0];
            sticky = ((lo_ext & ~({56{1'b1}} << d[5:0])) != 56'd0);
        end
        lo_sh[0] = lo_sh[0] | sticky;
        ax = a[62:52] == 11'h7FF;
        bx = b[62:52] == 11'h7FF;
        spec = ax || bx;
        if (drop_pkg::is_nan(a))
            spec_val = a | drop_pkg::QNAN_BIT;
        else if (drop_pkg::is_nan(b))
            spec_val = b | drop_pkg::QNAN_BIT;
        else if (ax && bx && (a[63] != b[63]))
            spec_val = drop_pkg::DFLT_NAN;
        else if (ax)
            spec_val = a;
        else
            spec_val = b;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sign_reg     <= sh_s;
            s1_bsign_reg    <= a[63] & b[63];
            s1_sub_reg      <= sh_s ^ sl_s;
            s1_spec_reg     <= spec;
            s1_spec_val_reg <= spec_val;
            s1_exp_reg      <= eh;
            s1_big_reg      <= {mh, 3'b000};
            s1_small_reg    <= lo_sh;
        end
    end

    // Stage 2: add and normalize
    logic        s2_sign_reg, s2_spec_reg, s2_zero_reg;
    logic [63:0] s2_spec_val_reg;
    logic [12:0] s2_exp_reg;
    logic [56:0] s2_man_reg;

    logic [56:0] raw, nrm;
    logic [5:0]  lz;
    logic [12:0] e2;
    logic        zsign;

    always_comb
    begin
        raw = s1_sub_reg ? ({1'b0, s1_big_reg} - {1'b0, s1_small_reg})
                         : ({1'b0, s1_big_reg} + {1'b0, s1_small_reg});
        lz = 6'd0;
        for (int i = 56; i >= 0; i--)
        begin
            if (raw[i] && lz == 6'd0 && (56 - i) >= 0)
            begin
                lz = 6'(56 - i) | 6'd0;
                break;
            end
        end
        nrm = raw;
        e2  = {2'b00, s1_exp_reg};
        if (raw[56])
        begin
            nrm = {1'b0, raw[56:2], raw[1] | raw[0]};
            e2  = e2 + 13'd1;
        end else if (raw != 57'd0)
        begin
            // shift left by lz-1 but not below exponent 1
            if ({7'd0, lz} - 13'd1 < e2)
            begin
                nrm = raw << (lz - 6'd1);
                e2  = e2 - ({7'd0, lz} - 13'd1);
            end else begin
                nrm = raw << (e2[5:0] - 6'd1);
                e2  = 13'd0;
            end
        end
        zsign = s1_sub_reg ? s1_bsign_reg : s1_sign_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sign_reg     <= (raw == 57'd0) ? zsign : s1_sign_reg;
            s2_zero_reg     <= raw == 57'd0;
            s2_spec_reg     <= s1_spec_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_exp_reg      <= e2;
            s2_man_reg      <= nrm;
        end
    end

    // Stage 3: round to nearest even
    logic [63:0] sum_next;
    logic [53:0] rm;
    logic [12:0] e3;
    logic        rup;

    always_comb
    begin
        rup = s2_man_reg[2] && (s2_man_reg[1] || s2_man_reg[0] || s2_man_reg[3]);
        rm  = {1'b0, s2_man_reg[55:3]} + {53'd0, rup};
        e3  = s2_exp_reg;
        if (rm[53])
        begin
            rm = rm >> 1;
            e3 = e3 + 13'd1;
        end
        if (e3 == 13'd0 && rm[52])
            e3 = 13'd1;
        if (s2_spec_reg)
            sum_next = s2_spec_val_reg;
        else if (s2_zero_reg)
            sum_next = {s2_sign_reg, 63'd0};
        else if (e3 >= 13'd2047)
            sum_next = {s2_sign_reg, 11'h7FF, 52'd0};
        else
            sum_next = {s2_sign_reg, e3[10:0], rm[51:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sum <= sum_next;
    end
endmodule
`default_nettype wire

### hw/rtl/drop_fmul.sv
`default_nettype none
// Double multiply, round to nearest even, three register stages:
// partial products, product sum and normalize, round.
module drop_fmul (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic [63:0]      prod
);
    // Stage 1: four partial products of 27-bit low and 26-bit high mantissa halves
    logic        s1_sign_reg, s1_spec_reg, s1_zero_reg;
    logic [63:0] s1_spec_val_reg;
    logic [13:0] s1_exp_reg;
    logic [53:0] p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;

    logic [52:0] ma, mb;
    logic [13:0] ea, eb;
    logic        ax, bx, az, bz, spec;
    logic [63:0] spec_val;

    always_comb
    begin
        ma = {(a[62:52] != 11'd0), a[51:0]};
        mb = {(b[62:52] != 11'd0), b[51:0]};
        ea = (a[62:52] == 11'd0) ? 14'd1 : {3'd0, a[62:52]};
        eb = (b[62:52] == 11'd0) ? 14'd1 : {3'd0, b[62:52]};
        ax = a[62:52] == 11'h7FF;
        bx = b[62:52] == 11'h7FF;
        az = a[62:0] == 63'd0;
        bz = b[62:0] == 63'd0;
        spec = ax || bx;
        if (drop_pkg::is_nan(a))
            spec_val = a | drop_pkg::QNAN_BIT;
        else if (drop_pkg::is_nan(b))
            spec_val = b | drop_pkg::QNAN_BIT;
        else if ((ax && bz) || (bx && az))
            spec_val = drop_pkg::DFLT_NAN;
        else
            spec_val = {a[63] ^ b[63], 11'h7FF, 52'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sign_reg     <= a[63] ^ b[63];
            s1_spec_reg     <= spec;
            s1_zero_reg     <= az || bz;
            s1_spec_val_reg <= spec_val;
            s1_exp_reg      <= ea + eb;
            p_ll_reg <= {1'b0, ma[26:0]} * {1'b0, mb[26:0]};
            p_lh_reg <= {1'b0, ma[26:0]} * {mb[52:27]};
            p_hl_reg <= {ma[52:27]} * {1'b0, mb[26:0]};
            p_hh_reg <= {2'b0, ma[52:27]} * {2'b0, mb[52:27]};
        end
    end

    // Stage 2: sum partial products and normalize
    logic        s2_sign_reg, s2_spec_reg, s2_zero_reg;
    logic [63:0] s2_spec_val_reg;
    logic [13:0] s2_exp_reg;
    logic [55:0] s2_man_reg;

    logic [105:0] full;
    logic [6:0]   lz;
    logic [105:0] sh;
    logic [13:0]  e;
    logic [13:0]  tgt;
    logic [7:0]   rs;
    logic [105:0] rmask;

    function automatic logic [13:0] s2e(input logic [13:0] es, input logic [6:0] l);
        s2e = es - 14'd1022 - {7'd0, l};
    endfunction

    always_comb
    begin
        full = {52'd0, p_ll_reg} + ({52'd0, p_lh_reg} << 27)
             + ({52'd0, p_hl_reg} << 27) + ({52'd0, p_hh_reg} << 54);
        lz = 7'd0;
        for (int i = 105; i >= 0; i--)
        begin
            if (full[i])
            begin
                lz = 7'(105 - i);
                break;
            end
        end
        // value = full * 2^(e-1075-1075+...), leading bit placed at 105
        sh = full << lz;
        e  = s2e(s1_exp_reg, lz);
        rs = 8'd0;
        tgt = 14'd0;
        rmask = '0;
        if (e[13] || e == 14'd0)
        begin
            // subnormal: shift right to exponent 1
            tgt = 14'd1 - e;
            rs  = (tgt > 14'd110) ? 8'd110 : tgt[7:0];
            rmask = ~({106{1'b1}} << rs);
            sh = (sh >> rs) | {105'd0, ((sh & rmask) != 106'd0)};
            e  = 14'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sign_reg     <= s1_sign_reg;
            s2_spec_reg     <= s1_spec_reg;
            s2_zero_reg     <= s1_zero_reg;
            s2_spec_val_reg <= s1_spec_val_reg;
            s2_exp_reg      <= e;
            s2_man_reg      <= {sh[105:53], sh[52], sh[51], (sh[50:0] != 51'd0)};
        end
    end

    // Stage 3: round
    logic [63:0] prod_next;
    logic [53:0] rm;
    logic [13:0] e3;
    logic        g, st, rup;

    always_comb
    begin
        // s2_man_reg[55:3] is 53-bit mantissa, [2] guard, [1:0] sticky
        g   = s2_man_reg[2];
        st  = s2_man_reg[1] | s2_man_reg[0];
        rup = g && (st || s2_man_reg[3]);
        rm  = {1'b0, s2_man_reg[55:3]} + {53'd0, rup};
        e3  = s2_exp_reg;
        if (rm[53])
        begin
            rm = rm >> 1;
            e3 = e3 + 14'd1;
        end
        if (e3 == 14'd0 && rm[52])
            e3 = 14'd1;
        if (s2_spec_reg)
            prod_next = s2_spec_val_reg;
        else if (s2_zero_reg)
            prod_next = {s2_sign_reg, 63'd0};
        else if (!e3[13] && e3 >= 14'd2047)
            prod_next = {s2_sign_reg, 11'h7FF, 52'd0};
        else
            prod_next = {s2_sign_reg, e3[10:0], rm[51:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prod <= prod_next;
    end
endmodule
`default_nettype wire

### hw/rtl/drop_misc.sv
`default_nettype none
// Compare, logical and bitwise ops, three register stages:
// compare, truncate and combine; magnitude and normalize; round.
module drop_misc (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic [3:0]  op,
    output logic [63:0]      res
);
    // Stage 1
    logic [63:0] s1_val_reg, s1_int_reg;
    logic        s1_isint_reg;

    logic        nan_any, gt, lt;
    logic [63:0] ta, tb, iv, v;
    logic        ta_t, tb_t;

    // compare of two doubles as ordered keys
    function automatic logic [63:0] key(input logic [63:0] u);
        key = u[63] ? ~u : (u | 64'h8000000000000000);
    endfunction

    always_comb
    begin
        nan_any = drop_pkg::is_nan(a) || drop_pkg::is_nan(b);
        gt = !nan_any && (key(a) > key(b)) && !(a[62:0] == 63'd0 && b[62:0] == 63'd0);
        lt = !nan_any && (key(a) < key(b)) && !(a[62:0] == 63'd0 && b[62:0] == 63'd0);
        ta = drop_pkg::trunc_sat(a);
        tb = drop_pkg::trunc_sat(b);
        ta_t = drop_pkg::truth(a);
        tb_t = drop_pkg::truth(b);
        iv = 64'd0;
        v  = 64'd0;
        case (op)
            drop_pkg::OP_MAX:  v = gt ? a : b;
            drop_pkg::OP_MIN:  v = lt ? a : b;
            drop_pkg::OP_LAND: v = (ta_t && tb_t) ? drop_pkg::ONE_BITS : 64'd0;
            drop_pkg::OP_LOR:  v = (ta_t || tb_t) ? drop_pkg::ONE_BITS : 64'd0;
            drop_pkg::OP_LXOR: v = (ta_t != tb_t) ? drop_pkg::ONE_BITS : 64'd0;
            drop_pkg::OP_BAND: iv = ta & tb;
            drop_pkg::OP_BOR:  iv = ta | tb;
            default:           v = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_val_reg   <= v;
            s1_int_reg   <= iv;
            s1_isint_reg <= (op == drop_pkg::OP_BAND) || (op == drop_pkg::OP_BOR);
        end
    end

    // Stage 2: magnitude and normalize
    logic [63:0] s2_val_reg, s2_nrm_reg;
    logic        s2_isint_reg, s2_sign_reg, s2_zero_reg;
    logic [6:0]  s2_p_reg;

    logic [63:0] m, nrm;
    logic [6:0]  p;

    always_comb
    begin
        m = s1_int_reg[63] ? (~s1_int_reg + 64'd1) : s1_int_reg;
        p = 7'd0;
        for (int i = 63; i >= 0; i--)
        begin
            if (m[i])
            begin
                p = 7'(i);
                break;
            end
        end
        nrm = m << (7'd63 - p);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_val_reg   <= s1_val_reg;
            s2_isint_reg <= s1_isint_reg;
            s2_sign_reg  <= s1_int_reg[63];
            s2_zero_reg  <= s1_int_reg == 64'd0;
            s2_p_reg     <= p;
            s2_nrm_reg   <= nrm;
        end
    end

    // Stage 3: round to 53 bits
    logic [63:0] res_next;
    logic [53:0] rm;
    logic [10:0] e;
    logic        rup;

    always_comb
    begin
        rup = s2_nrm_reg[10] && ((s2_nrm_reg[9:0] != 10'd0) || s2_nrm_reg[11]);
        rm  = {1'b0, s2_nrm_reg[63:11]} + {53'd0, rup};
        e   = 11'd1023 + {4'd0, s2_p_reg};
        if (rm[53])
        begin
            rm = rm >> 1;
            e  = e + 11'd1;
        end
        if (!s2_isint_reg)
            res_next = s2_val_reg;
        else if (s2_zero_reg)
            res_next = 64'd0;
        else
            res_next = {s2_sign_reg, e, rm[51:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res <= res_next;
    end
endmodule
`default_nettype wire

### hw/rtl/double_reduction_op_alu.sv
`default_nettype none
// Element-wise reduction ALU on IEEE-754 double words.
// Input channel: operand_a, operand_b, last_in with in_valid / in_stall.
// Output channel: result_bits, last_out with out_valid / out_stall.
// Config: cfg_we with cfg_data writes the operation register (reset 0 = max);
// write it only while no word is in flight.
// An accepted word moves through three register stages to out_valid; one word
// per cycle sustained while out_stall does not hold the pipeline. All three
// units (add, multiply, compare/logic/bitwise) run in parallel three-stage
// pipelines and the operation picks the final result.
// A stall on the output while the last stage holds a word freezes the whole
// pipeline and raises in_stall in the same cycle; bubbles are not squeezed
// out. A stall with the last stage empty holds nothing.
// Reset clears all valid bits; no word is lost or repeated across a stall.
module double_reduction_op_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] operand_a,
    input  wire logic [63:0] operand_b,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_bits,
    output logic             last_out
);
    logic [3:0] op_reg;
    logic [2:0] v_reg;
    logic [2:0] last_reg;
    logic [3:0] op1_reg, op2_reg, op3_reg;
    logic       adv;

    logic [63:0] sum, prod, misc;

    // Advance when the output is free
    assign adv      = !(v_reg[2] && out_stall);
    assign in_stall = !adv;

    // Hold operation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_reg <= 4'd0;
        else if (cfg_we)
            op_reg <= cfg_data;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 3'd0;
        else if (adv)
            v_reg <= {v_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[1:0], last_in};
            op1_reg  <= op_reg;
            op2_reg  <= op1_reg;
            op3_reg  <= op2_reg;
        end
    end

    drop_fadd u_fadd (
        .clk (clk), .adv (adv),
        .a (operand_a), .b (operand_b), .sum (sum)
    );

    drop_fmul u_fmul (
        .clk (clk), .adv (adv),
        .a (operand_a), .b (operand_b), .prod (prod)
    );

    drop_misc u_misc (
        .clk (clk), .adv (adv),
        .a (operand_a), .b (operand_b), .op (op_reg), .res (misc)
    );

    // Select the result word
    always_comb
    begin
        case (op3_reg)
            drop_pkg::OP_SUM:  result_bits = sum;
            drop_pkg::OP_PROD: result_bits = prod;
            default:           result_bits = misc;
        endcase
    end

    assign out_valid = v_reg[2];
    assign last_out  = last_reg[2];
endmodule
`default_nettype wire

### hw/rtl/drop_checker.sv
`default_nettype none
`include "assert_macros.svh"
module drop_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic last_out
);
    // Input stalls only while an output word waits
    `CHK_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall, "stall without cause")
    // A stalled output word stays
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "output dropped")
    // A stalled last flag holds
    `CHK_NEXT(a_last_hold, clk, rst_n, out_valid && out_stall, $stable(last_out), "last changed")
    // An accepted word shows on the output if out_stall stays low meanwhile
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("latency");
endmodule

bind double_reduction_op_alu drop_checker u_chk (.*);
`default_nettype wire

### tb/sv/double_reduction_op_alu_test.sv
`default_nettype none
module double_reduction_op_alu_test;

    localparam logic [3:0]  OP_NONE  = 4'd15;   // code outside the defined set
    localparam logic [63:0] SIGN_MSK = 64'h8000000000000000;
    localparam logic [63:0] MANT_MSK = 64'h000FFFFFFFFFFFFF;
    localparam logic [63:0] POS_INF  = 64'h7FF0000000000000;
    localparam longint      CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [63:0] bits;
        logic        last;
    } result_t;

    // Expected results and the predictor of the ALU
    class reduction_board;
        logic [3:0] op;
        result_t    pending[$];
        int         errors;

        function new();
            op = drop_pkg::OP_MAX;
            errors = 0;
        endfunction

        function bit nan_of(logic [63:0] u);
            return (u[62:52] == 11'h7FF) && (u[51:0] != 0);
        endfunction

        function bit nonzero(logic [63:0] u);
            return u[62:0] != 0;
        endfunction

        // Truncate to saturated int64 bits
        function logic [63:0] to_int(logic [63:0] u);
            logic [10:0] ex;
            logic [63:0] mag;
            ex = u[62:52];
            if (nan_of(u) || ex < 11'd1023) return 64'd0;
            if (ex >= 11'd1086) return u[63] ? SIGN_MSK : ~SIGN_MSK;
            mag = (u & MANT_MSK) | (64'd1 << 52);
            if (ex >= 11'd1075) mag = mag << (ex - 11'd1075);
            else mag = mag >> (11'd1075 - ex);
            return u[63] ? (~mag + 64'd1) : mag;
        endfunction

        // int64 bits back to double, nearest-even
        function logic [63:0] from_int(logic [63:0] v);
            logic [63:0] m, mant, rem, half;
            int p, sh;
            m = v[63] ? (~v + 64'd1) : v;
            if (m == 0) return 64'd0;
            p = 63;
            while (m[p] == 1'b0) p--;
            if (p <= 52) begin
                mant = m << (52 - p);
            end else begin
                sh   = p - 52;
                rem  = m & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 1);
                mant = m >> sh;
                if (rem > half || (rem == half && mant[0])) mant++;
                if (mant == (64'd1 << 53)) begin
                    mant = mant >> 1;
                    p++;
                end
            end
            return (v & SIGN_MSK) | (64'(p + 1023) << 52) | (mant & MANT_MSK);
        endfunction

        function logic [63:0] fix_nan(logic [63:0] a, logic [63:0] b, logic [63:0] r);
            if (!nan_of(r)) return r;
            if (nan_of(a)) return a | drop_pkg::QNAN_BIT;
            if (nan_of(b)) return b | drop_pkg::QNAN_BIT;
            return drop_pkg::DFLT_NAN;
        endfunction

        function logic [63:0] reduce(logic [63:0] a, logic [63:0] b);
            real ra, rb;
            bit unordered;
            ra = $bitstoreal(a);
            rb = $bitstoreal(b);
            unordered = nan_of(a) || nan_of(b);
            case (op)
                drop_pkg::OP_MAX:  return (!unordered && ra > rb) ? a : b;
                drop_pkg::OP_MIN:  return (!unordered && ra < rb) ? a : b;
                drop_pkg::OP_SUM:  return fix_nan(a, b, $realtobits(ra + rb));
                drop_pkg::OP_PROD: return fix_nan(a, b, $realtobits(ra * rb));
                drop_pkg::OP_LAND:
                    return (nonzero(a) && nonzero(b)) ? drop_pkg::ONE_BITS : 64'd0;
                drop_pkg::OP_BAND: return from_int(to_int(a) & to_int(b));
                drop_pkg::OP_LOR:
                    return (nonzero(a) || nonzero(b)) ? drop_pkg::ONE_BITS : 64'd0;
                drop_pkg::OP_BOR:  return from_int(to_int(a) | to_int(b));
                drop_pkg::OP_LXOR:
                    return (nonzero(a) != nonzero(b)) ? drop_pkg::ONE_BITS : 64'd0;
                default: return 64'd0;
            endcase
        endfunction

        // Note an accepted input word
        function void note(logic [63:0] a, logic [63:0] b, logic l);
            result_t e;
            e.bits = reduce(a, b);
            e.last = l;
            pending.push_back(e);
        endfunction

        // Check a delivered result word
        function void check(logic [63:0] r, logic l);
            result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h last %b", $time, r, l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r !== e.bits) begin
                $display("%0t: op %0d result expected %h actual %h", $time, op, e.bits, r);
                errors++;
            end
            if (l !== e.last) begin
                $display("%0t: last expected %b actual %b", $time, e.last, l);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_data = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] operand_a = 64'd0;
    logic [63:0] operand_b = 64'd0;
    logic        last_in = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result_bits;
    logic        last_out;

    reduction_board board = new();
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    int     hold_cycles = 0;
    longint cycles = 0;

    double_reduction_op_alu i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operand_a(operand_a), .operand_b(operand_b), .last_in(last_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_bits(result_bits), .last_out(last_out)
    );

    always #4 clk = ~clk;

    // Drive stall, hold off on request, check results
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            board.check(result_bits, last_out);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Random operand: special values, random bits, integer-range values
    function automatic logic [63:0] pick_operand();
        logic [63:0] u;
        u = {$urandom, $urandom};
        case ($urandom_range(9))
            0: u = u & SIGN_MSK;                                  // signed zero
            1: u = (u & SIGN_MSK) | POS_INF;                      // infinity
            2: u = (u & ~MANT_MSK) | POS_INF | 64'd1;             // nan
            3: u = u & (SIGN_MSK | MANT_MSK);                     // subnormal
            4, 5, 6: u[62:52] = 11'(1010 + $urandom_range(80));   // near int range
            default: ;
        endcase
        return u;
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(logic [63:0] a, logic [63:0] b, logic l);
        operand_a <= a;
        operand_b <= b;
        last_in   <= l;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note(a, b, l);
        if ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Wait for the pipeline to empty, then set the operation
    task automatic set_operation(logic [3:0] op);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= op;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.op = op;
    endtask

    logic [63:0] edge_vals[12] = '{
        64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
        64'hFFF0000000000000, 64'h7FF0000000000001, 64'hFFFFFFFFFFFFFFFF,
        64'h0000000000000001, 64'h3FF0000000000000, 64'hC3E0000000000000,
        64'h43E0000000000000, 64'h7FEFFFFFFFFFFFFF, 64'hBFE0000000000000
    };
    logic [3:0] op_seq[11] = '{drop_pkg::OP_LAND, drop_pkg::OP_MAX, drop_pkg::OP_MIN,
                               drop_pkg::OP_SUM, drop_pkg::OP_PROD, drop_pkg::OP_BAND,
                               drop_pkg::OP_LOR, drop_pkg::OP_BOR, drop_pkg::OP_LXOR,
                               OP_NONE, drop_pkg::OP_MAX};

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (op_seq[s])
        begin
            set_operation(op_seq[s]);
            tx_idle_pct  = (s % 4 == 1 || s % 4 == 3) ? ((s % 4 == 3) ? 27 : 86) : 0;
            rx_stall_pct = (s % 4 == 2 || s % 4 == 3) ? ((s % 4 == 3) ? 27 : 86) : 0;
            // Directed: extreme values against each other
            for (int i = 0; i < 12; i++)
                send_word(edge_vals[i], edge_vals[(i * 5 + 3) % 12], i[0]);
            send_word(edge_vals[8], edge_vals[8], 1'b1);
            // Long receiver hold while the sender keeps offering
            if (s == 3) hold_cycles = 300;
            for (int i = 0; i < 155; i++)
            begin
                logic [63:0] a, b;
                a = pick_operand();
                b = ($urandom_range(9) == 0) ? a : pick_operand();
                send_word(a, b, $urandom_range(1));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
